// File: src/packet_bit_field_reader_top_macros.svh
// Assertion macros for the packet bit field reader.
`ifndef PACKET_BIT_FIELD_READER_TOP_MACROS_SVH
`define PACKET_BIT_FIELD_READER_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define PBR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbr: implication violated");
// Next-cycle implication, checked on every rising edge outside reset.
`define PBR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbr: next-cycle implication violated");
`else
`define PBR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PBR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: src/pbr_pkg.sv
// Shared types and constants of the packet bit field reader.
package pbr_pkg;

  localparam int unsigned STORE_BYTES   = 256;
  localparam int unsigned ADDR_W        = $clog2(STORE_BYTES);
  localparam int unsigned POS_W         = 12;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned FIELD_BITS    = 32;
  localparam int unsigned VARINT_GROUPS = 5;
  localparam int unsigned GRP_W         = 3;
  localparam int unsigned GROUP_BITS    = 8;

  // Largest packet length the store can hold, in bits.
  localparam logic [POS_W-1:0] LIMIT_CAP = POS_W'(STORE_BYTES * 8);

  // Item kinds.
  localparam logic [2:0] MODE_LOAD    = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_FIELD   = 3'd2;
  localparam logic [2:0] MODE_BOUNDED = 3'd3;
  localparam logic [2:0] MODE_VARINT  = 3'd4;
  localparam logic [2:0] MODE_BIT     = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         byte_addr;
    logic [7:0]         data_byte;
    logic [POS_W-1:0]   bit_length;
    logic [CNT_W-1:0]   bit_count;
    logic [VALUE_W-1:0] value_max;
  } pbr_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   bits_left;
  } pbr_out_t;

  // Request from the sequencer to the byte store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pbr_mem_req_t;

endpackage

// File: src/pbr_store.sv
// Packet byte store: one write port, one read port with registered data.
module pbr_store
  import pbr_pkg::*;
(
  input  logic         clk_i,
  input  pbr_mem_req_t req_i,
  output logic [7:0]   rd_data_o
);

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rd_data_q;

  // Byte write and registered byte read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/pbr_engine.sv
// Bit-serial read sequencer: holds position, length and error, walks fields a bit a cycle, pausing for each byte load.
module pbr_engine
  import pbr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  pbr_in_t      in_i,
  output logic         in_ready_o,
  output pbr_mem_req_t mem_o,
  input  logic [7:0]   rd_data_i,
  output logic         res_valid_o,
  output pbr_out_t     res_o,
  input  logic         res_ready_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_LOAD,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [2:0]         kind_q, kind_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   limit_q, limit_d;
  logic               ovf_q, ovf_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [VALUE_W-1:0] vmax_q, vmax_d;
  logic [7:0]         win_q, win_d;
  logic               win_empty_q, win_empty_d;
  logic [GRP_W-1:0]   grp_q, grp_d;
  logic [2:0]         gbit_q, gbit_d;
  logic               cont_q, cont_d;
  logic               stop_q, stop_d;

  logic [VALUE_W-1:0] mask;
  logic [POS_W:0]     field_end;
  logic [POS_W:0]     group_end;
  logic               go;
  logic               ovf_hit;
  logic               fetch;

  assign mask      = VALUE_W'(1) << cnt_q[4:0];
  assign field_end = {1'b0, pos_q} + {{(POS_W + 1 - CNT_W){1'b0}}, in_i.bit_count};
  assign group_end = {1'b0, pos_q} + (POS_W + 1)'(GROUP_BITS);

  // Per-kind decision: take another bit, or stop (possibly on overflow)
  always_comb begin
    go      = 1'b0;
    ovf_hit = 1'b0;
    unique case (kind_q) inside
      MODE_FIELD, MODE_BIT: begin
        go = cnt_q < n_q;
      end
      MODE_BOUNDED: begin
        // value has no bits at or above the mask, so value + mask == value | mask
        go      = !cnt_q[CNT_W-1] && ((val_q | mask) < vmax_q);
        ovf_hit = go && (pos_q >= limit_q);
      end
      MODE_VARINT: begin
        if (gbit_q == 3'd0) begin
          go      = !stop_q && (grp_q != GRP_W'(VARINT_GROUPS));
          ovf_hit = go && (group_end > {1'b0, limit_q});
        end else begin
          go = 1'b1;
        end
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  assign fetch = (state_q == ST_BIT) && go && !ovf_hit && win_empty_q;

  // Store access: writes for load items, byte fetches during a read
  always_comb begin
    mem_o.we    = in_valid_i && (state_q == ST_IDLE) && (in_i.mode == MODE_LOAD);
    mem_o.waddr = in_i.byte_addr[ADDR_W-1:0];
    mem_o.wdata = in_i.data_byte;
    mem_o.re    = fetch;
    mem_o.raddr = pos_q[ADDR_W+2:3];
  end

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    limit_d     = limit_q;
    ovf_d       = ovf_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    vmax_d      = vmax_q;
    win_d       = win_q;
    win_empty_d = win_empty_q;
    grp_d       = grp_q;
    gbit_d      = gbit_q;
    cont_d      = cont_q;
    stop_d      = stop_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d      = in_i.mode;
          val_d       = '0;
          cnt_d       = '0;
          n_d         = in_i.bit_count;
          vmax_d      = in_i.value_max;
          win_empty_d = 1'b1;
          grp_d       = '0;
          gbit_d      = '0;
          cont_d      = 1'b0;
          stop_d      = 1'b0;
          state_d     = ST_DONE;
          case (in_i.mode)
            MODE_START: begin
              limit_d = (in_i.bit_length > LIMIT_CAP) ? LIMIT_CAP : in_i.bit_length;
              pos_d   = '0;
              ovf_d   = 1'b0;
            end
            MODE_FIELD: begin
              if (ovf_q || (in_i.bit_count > CNT_W'(FIELD_BITS)) ||
                  (field_end > {1'b0, limit_q})) begin
                ovf_d = 1'b1;
              end else if (in_i.bit_count != '0) begin
                state_d = ST_BIT;
              end
            end
            MODE_BOUNDED, MODE_VARINT: begin
              if (!ovf_q) begin
                state_d = ST_BIT;
              end
            end
            MODE_BIT: begin
              // single bit fails quietly at the end of the packet
              n_d = CNT_W'(1);
              if (!ovf_q && (pos_q < limit_q)) begin
                state_d = ST_BIT;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_BIT: begin
        if (!go) begin
          state_d = ST_DONE;
        end else if (ovf_hit) begin
          ovf_d   = 1'b1;
          state_d = ST_DONE;
        end else if (win_empty_q) begin
          state_d = ST_LOAD;
        end else begin
          // consume one bit from the window
          pos_d = pos_q + POS_W'(1);
          win_d = win_q >> 1;
          if (pos_d[2:0] == 3'd0) begin
            win_empty_d = 1'b1;
          end
          if (kind_q == MODE_VARINT) begin
            gbit_d = gbit_q + 3'd1;
            if (gbit_q == 3'd0) begin
              cont_d = win_q[0];
            end else begin
              if (!cnt_q[CNT_W-1]) begin
                val_d[cnt_q[4:0]] = win_q[0];
              end
              cnt_d = cnt_q + CNT_W'(1);
            end
            if (gbit_q == 3'd7) begin
              grp_d  = grp_q + GRP_W'(1);
              stop_d = !cont_q;
            end
          end else begin
            val_d[cnt_q[4:0]] = win_q[0];
            cnt_d             = cnt_q + CNT_W'(1);
          end
        end
      end

      ST_LOAD: begin
        win_d       = rd_data_i >> pos_q[2:0];
        win_empty_d = 1'b0;
        state_d     = ST_BIT;
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= MODE_LOAD;
      pos_q       <= '0;
      limit_q     <= '0;
      ovf_q       <= 1'b0;
      val_q       <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      vmax_q      <= '0;
      win_q       <= '0;
      win_empty_q <= 1'b1;
      grp_q       <= '0;
      gbit_q      <= '0;
      cont_q      <= 1'b0;
      stop_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      pos_q       <= pos_d;
      limit_q     <= limit_d;
      ovf_q       <= ovf_d;
      val_q       <= val_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      vmax_q      <= vmax_d;
      win_q       <= win_d;
      win_empty_q <= win_empty_d;
      grp_q       <= grp_d;
      gbit_q      <= gbit_d;
      cont_q      <= cont_d;
      stop_q      <= stop_d;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign res_valid_o     = (state_q == ST_DONE);
  assign res_o.value     = val_q;
  assign res_o.error     = ovf_q;
  assign res_o.position  = pos_q;
  assign res_o.bits_left = limit_q - pos_q;

endmodule

// File: src/packet_bit_field_reader_top.sv
// Packet bit field reader: a 256-byte packet store, loaded a byte per transfer, read back
// LSB first as plain fields (0 to 32 bits), bounded integers, varints (up to five 8-bit
// groups, continue flag in bit 0) and single bits, with a sticky overflow flag set by a
// read past the packet length. One item is worked on at a time, one bit per cycle except
// while a byte is fetched and loaded into the window: load, start and reads settled when
// taken (a field that fails or has zero width, any read with the flag set, a single bit at
// the end of the packet, unused kinds) go straight to the result; a read that walks bits
// over stored bytes passes through the accepting step, a fetch and a window load per byte
// touched, a step per bit, a final check and the result. A stalled output holds results
// back. The result of the previous item may still wait in the output register while the
// next item is taken.
`include "packet_bit_field_reader_top_macros.svh"

module packet_bit_field_reader_top
  import pbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pbr_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pbr_out_t out_o
);

  pbr_mem_req_t mem_req;
  logic [7:0]   rd_data;
  logic         eng_ready;
  logic         res_valid;
  logic         res_ready;
  pbr_out_t     res;

  logic         out_valid_q, out_valid_d;
  pbr_out_t     out_q, out_d;
  logic [POS_W:0] limit_sum;
  logic         result_ok;

  pbr_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  pbr_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_ready_o  (eng_ready),
    .mem_o       (mem_req),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign in_stall_o = !eng_ready;

  // Output register: takes a result when empty or when its transfer completes
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Position plus bits left gives the packet length, never above the store size
  assign limit_sum = {1'b0, out_q.position} + {1'b0, out_q.bits_left};
  assign result_ok = (out_q.position <= LIMIT_CAP) && (limit_sum <= (POS_W + 1)'(LIMIT_CAP));

  `PBR_ASSERT_IMP(a_idle_no_result, clk_i, rst_ni, !in_stall_o, !res_valid)
  `PBR_ASSERT_NEXT(a_accept_goes_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `PBR_ASSERT_IMP(a_result_in_range, clk_i, rst_ni, out_valid_q, result_ok)

endmodule
